@@ design/triangle_raster_depth_test_macros.svh @@
// Assertion macros for the triangle rasterizer with depth buffer.
// Included by the top level; no other dependencies.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_MACROS_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TRD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TRD_ASSERT_RESET(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TRD_ASSERT_RESET(label, clk, prop, msg)
`endif
`endif

@@ design/trd_pkg.sv @@
// Shared types and constants for the triangle rasterizer with depth buffer.
// No dependencies.
package trd_pkg;
    localparam int ScreenWidth  = 256;
    localparam int ScreenHeight = 256;
    localparam int PixCount     = ScreenWidth * ScreenHeight;
    localparam int AddrW        = $clog2(PixCount);
    localparam int XW           = $clog2(ScreenWidth);
    localparam int YW           = $clog2(ScreenHeight);

    typedef enum logic [2:0] {
        KIND_DRAW  = 3'd0,
        KIND_READ  = 3'd1,
        KIND_CLR_C = 3'd2,
        KIND_CLR_Z = 3'd3,
        KIND_CLR_B = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] vert0_x;
        logic [11:0] vert0_y;
        logic [23:0] vert0_z;
        logic [11:0] vert1_x;
        logic [11:0] vert1_y;
        logic [23:0] vert1_z;
        logic [11:0] vert2_x;
        logic [11:0] vert2_y;
        logic [23:0] vert2_z;
        logic [23:0] fill_color;
        logic [15:0] pixel_addr;
    } in_item_t;

    typedef struct packed {
        logic [16:0] pixels_written;
        logic [23:0] read_color;
        logic [23:0] read_depth;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_SETUP, ST_EDGE, ST_MUL, ST_DIVIDE, ST_RDMEM,
        ST_TEST, ST_NEXT, ST_READ, ST_READ2, ST_CLEAR, ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic edge_calc;
        logic mul;
        logic div_start;
        logic mem_read;
        logic test;
        logic advance;
        logic read_addr;
        logic read_cap;
        logic clr_start;
        logic clr_step;
        logic clr_color;
        logic clr_depth;
        logic set_result;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic box_empty;
        logic covered;
        logic div_busy;
        logic last_pixel;
        logic clr_last;
    } status_t;
endpackage

@@ design/trd_if.sv @@
// Valid/ready channel interface carrying one payload type.
// No dependencies.
interface trd_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/triangle_raster_depth_test.sv @@
// Top level of the triangle rasterizer with depth buffer.
// Depends on trd_pkg, trd_if, trd_ctrl, trd_datapath and the macro header.
//
//  channel   modport  payload
//  in_ch     sink     in_item_t  (kind, three vertices, fill_color, pixel_addr)
//  out_ch    source   out_item_t (pixels_written, read_color, read_depth)
//
// A draw walks every box pixel and sends each covered pixel through the
// one-bit-per-cycle depth divider (64 quotient bits).
// A clear writes all 65536 store entries, one per cycle, over the single write port.
// After reset a clearing pass runs before the first item is taken.
// A result waits in the output register while the next item is taken; the next
// result holds until the waiting one is taken.
`include "triangle_raster_depth_test_macros.svh"
module triangle_raster_depth_test
    import trd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    trd_if.sink   in_ch,
    trd_if.source out_ch
);
    cmd_t    cmd;
    status_t status;
    out_item_t result;

    trd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_kind   (in_ch.data.kind),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    trd_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch.data),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    assign out_ch.data = result;

    `TRD_ASSERT_IMPL(a_out_hold, clk, rst_n,
        (out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data)),
        "result beat changed while stalled")
    `TRD_ASSERT_IMPL(a_test_after_read, clk, rst_n,
        (cmd.test |-> $past(cmd.mem_read)), "depth test without a store read")
endmodule

@@ design/trd_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 40-bit divisor.
// Depends on trd_pkg.
module trd_div
    import trd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [63:0] quot_reg, quot_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic [40:0] trial;
    logic [40:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg[39:0], quot_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        quot_next = {quot_reg[62:0], 1'b0};
        rem_next  = shifted;
        cnt_next  = cnt_reg;
        if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (!trial[40])
            begin
                rem_next     = trial;
                quot_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 7'd64;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (cnt_reg != 7'd0)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy     = (cnt_reg != 7'd0);
    assign quotient = quot_reg;
endmodule

@@ design/trd_datapath.sv @@
// Datapath: bounding box walk, edge functions, depth interpolation and the stores.
// Depends on trd_pkg and trd_div.
module trd_datapath
    import trd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  cmd_t      cmd,
    output status_t   status,
    output out_item_t result
);
    logic signed [13:0] vx_reg [3];
    logic signed [13:0] vy_reg [3];
    logic [23:0] vz_reg [3];
    logic [23:0] col_reg;
    logic [15:0] raddr_reg;
    logic [8:0]  x0_reg, x_reg, xmax_reg, y0_reg, y_reg, ymax_reg;
    logic [11:0] minx, maxx, miny, maxy;
    logic signed [26:0] w_reg [3];
    logic [25:0] wa_reg [3];
    logic [49:0] p_reg [3];
    logic [23:0] z_reg;
    logic [16:0] count_reg;
    logic [AddrW-1:0] idx_reg;
    logic [AddrW-1:0] clr_reg;
    logic [23:0] depth_mem [PixCount];
    logic [23:0] color_mem [PixCount];
    logic [23:0] dq_reg, cq_reg;
    logic        raddr_ok_reg;
    out_item_t   result_reg;
    logic        div_busy;
    logic [63:0] quotient;
    logic [63:0] num;
    logic [39:0] den;
    logic signed [13:0] px, py;
    logic signed [26:0] w_calc [3];
    logic        pos, neg, on_screen;
    logic        col_kind_draw_reg;

    always_comb
    begin
        minx = item.vert0_x; maxx = item.vert0_x;
        miny = item.vert0_y; maxy = item.vert0_y;
        if (item.vert1_x < minx) minx = item.vert1_x;
        if (item.vert2_x < minx) minx = item.vert2_x;
        if (item.vert1_x > maxx) maxx = item.vert1_x;
        if (item.vert2_x > maxx) maxx = item.vert2_x;
        if (item.vert1_y < miny) miny = item.vert1_y;
        if (item.vert2_y < miny) miny = item.vert2_y;
        if (item.vert1_y > maxy) maxy = item.vert1_y;
        if (item.vert2_y > maxy) maxy = item.vert2_y;
    end

    // Last column is ceil(max/16)-1; the box is empty when ceil(max/16) <= floor(min/16).
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg[0] <= {2'b00, item.vert0_x};
            vy_reg[0] <= {2'b00, item.vert0_y};
            vz_reg[0] <= item.vert0_z;
            vx_reg[1] <= {2'b00, item.vert1_x};
            vy_reg[1] <= {2'b00, item.vert1_y};
            vz_reg[1] <= item.vert1_z;
            vx_reg[2] <= {2'b00, item.vert2_x};
            vy_reg[2] <= {2'b00, item.vert2_y};
            vz_reg[2] <= item.vert2_z;
            col_reg   <= item.fill_color;
            raddr_reg <= item.pixel_addr;
            x0_reg    <= {1'b0, minx[11:4]};
            y0_reg    <= {1'b0, miny[11:4]};
            xmax_reg  <= {1'b0, maxx[11:4]} + {8'd0, (maxx[3:0] != 4'd0)};
            ymax_reg  <= {1'b0, maxy[11:4]} + {8'd0, (maxy[3:0] != 4'd0)};
        end
        if (cmd.setup)
        begin
            x_reg <= x0_reg;
            y_reg <= y0_reg;
        end
        else if (cmd.advance)
        begin
            if (y_reg + 9'd1 >= ymax_reg)
            begin
                y_reg <= y0_reg;
                x_reg <= x_reg + 9'd1;
            end
            else
                y_reg <= y_reg + 9'd1;
        end
    end

    assign status.box_empty  = (x0_reg >= xmax_reg) || (y0_reg >= ymax_reg);
    assign status.last_pixel = (y_reg + 9'd1 >= ymax_reg) && (x_reg + 9'd1 >= xmax_reg);

    assign px = {1'b0, x_reg, 4'd0};
    assign py = {1'b0, y_reg, 4'd0};

    always_comb
    begin
        w_calc[0] = (27'(vx_reg[2] - vx_reg[1]) * 27'(py - vy_reg[1]))
                  - (27'(vy_reg[2] - vy_reg[1]) * 27'(px - vx_reg[1]));
        w_calc[1] = (27'(vx_reg[0] - vx_reg[2]) * 27'(py - vy_reg[2]))
                  - (27'(vy_reg[0] - vy_reg[2]) * 27'(px - vx_reg[2]));
        w_calc[2] = (27'(vx_reg[1] - vx_reg[0]) * 27'(py - vy_reg[0]))
                  - (27'(vy_reg[1] - vy_reg[0]) * 27'(px - vx_reg[0]));
    end

    assign pos = (w_reg[0] > 0) && (w_reg[1] > 0) && (w_reg[2] > 0);
    assign neg = (w_reg[0] < 0) && (w_reg[1] < 0) && (w_reg[2] < 0);
    assign on_screen = (x_reg < 9'(ScreenWidth)) && (y_reg < 9'(ScreenHeight));
    assign status.covered = (pos || neg) && on_screen;

    always_ff @(posedge clk)
    begin
        if (cmd.edge_calc)
        begin
            for (int i = 0; i < 3; i++)
                w_reg[i] <= w_calc[i];
            idx_reg <= AddrW'((ScreenHeight - 1 - 32'(y_reg)) * ScreenWidth + 32'(x_reg));
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wa_reg[i] <= neg ? 26'(-w_reg[i]) : 26'(w_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            for (int i = 0; i < 3; i++)
                p_reg[i] <= 50'(wa_reg[i]) * 50'(vz_reg[i]);
        end
    end

    // Products are registered with div_start; the divider loads them in the cycle after.
    assign den = 40'(wa_reg[0]) + 40'(wa_reg[1]) + 40'(wa_reg[2]);
    assign num = 64'(p_reg[0]) + 64'(p_reg[1]) + 64'(p_reg[2]) + 64'(den[39:1]);

    logic div_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= cmd.div_start;
    end

    trd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (num),
        .divisor  (den),
        .busy     (div_busy),
        .quotient (quotient)
    );
    assign status.div_busy = div_busy || div_go_reg || cmd.div_start;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
            z_reg <= (quotient[63:24] != '0) ? 24'hFFFFFF : quotient[23:0];
    end

    // Depth store: the clear pass and pixel writes share one write port.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
            dq_reg <= depth_mem[idx_reg];
        else if (cmd.read_addr)
            dq_reg <= depth_mem[raddr_reg[AddrW-1:0]];
        if (cmd.read_addr)
            cq_reg <= color_mem[raddr_reg[AddrW-1:0]];
        if (cmd.test && z_reg <= dq_reg)
        begin
            depth_mem[idx_reg] <= z_reg;
            color_mem[idx_reg] <= col_reg;
        end
        else if (cmd.clr_step)
        begin
            if (cmd.clr_depth)
                depth_mem[clr_reg] <= 24'hFFFFFF;
            if (cmd.clr_color)
                color_mem[clr_reg] <= 24'd0;
        end
    end

    // The clear counter starts from zero after reset for the initial clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_start)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + AddrW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_addr)
            raddr_ok_reg <= (32'(raddr_reg) < PixCount);
    end
    assign status.clr_last = (clr_reg == AddrW'(PixCount - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            col_kind_draw_reg <= (item.kind == KIND_DRAW);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
            count_reg <= '0;
        else if (cmd.test && z_reg <= dq_reg)
            count_reg <= count_reg + 17'd1;
        if (cmd.set_result)
        begin
            result_reg.pixels_written <= (col_kind_draw_reg) ? count_reg : 17'd0;
            result_reg.read_color     <= '0;
            result_reg.read_depth     <= '0;
        end
        else if (cmd.read_cap)
        begin
            result_reg.pixels_written <= '0;
            result_reg.read_color     <= raddr_ok_reg ? cq_reg : 24'd0;
            result_reg.read_depth     <= raddr_ok_reg ? dq_reg : 24'd0;
        end
    end

    assign result = result_reg;
endmodule

@@ design/trd_ctrl.sv @@
// Controller state machine sequencing draw, read and clear items.
// Depends on trd_pkg.
module trd_ctrl
    import trd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic [2:0] in_kind,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t state_reg, state_next;
    logic   clr_c_reg, clr_c_next, clr_z_reg, clr_z_next;
    logic   ov_reg, ov_next;
    logic   out_free;
    // Products are formed the cycle after the weights become absolute.
    logic   first_div_reg;

    // The output register can take a new result when it is empty or being emptied.
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        clr_c_next = clr_c_reg;
        clr_z_next = clr_z_reg;
        unique case (state_reg)
            ST_INIT:   if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                begin
                    unique case (in_kind)
                        KIND_DRAW: state_next = ST_SETUP;
                        KIND_READ: state_next = ST_READ;
                        KIND_CLR_C, KIND_CLR_Z, KIND_CLR_B:
                        begin
                            state_next = ST_CLEAR;
                            clr_c_next = (in_kind != KIND_CLR_Z);
                            clr_z_next = (in_kind != KIND_CLR_C);
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_SETUP:  state_next = status.box_empty ? ST_DONE : ST_EDGE;
            ST_EDGE:   state_next = ST_MUL;
            ST_MUL:    state_next = status.covered ? ST_DIVIDE : ST_NEXT;
            ST_DIVIDE: if (!status.div_busy) state_next = ST_RDMEM;
            ST_RDMEM:  state_next = ST_TEST;
            ST_TEST:   state_next = ST_NEXT;
            ST_NEXT:   state_next = status.last_pixel ? ST_DONE : ST_EDGE;
            ST_READ:   state_next = ST_READ2;
            ST_READ2:  if (out_free) state_next = ST_IDLE;
            ST_CLEAR:  if (status.clr_last) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step  = 1'b1;
                cmd.clr_color = 1'b1;
                cmd.clr_depth = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load      = in_valid;
                cmd.clr_start = 1'b1;
            end
            ST_SETUP:  cmd.setup = 1'b1;
            ST_EDGE:   cmd.edge_calc = 1'b1;
            ST_MUL:    cmd.mul = 1'b1;
            ST_DIVIDE: cmd.div_start = first_div_reg;
            ST_RDMEM:  cmd.mem_read = 1'b1;
            ST_TEST:   cmd.test = 1'b1;
            ST_NEXT:   cmd.advance = 1'b1;
            ST_READ:   cmd.read_addr = 1'b1;
            ST_READ2:
                if (out_free)
                begin
                    cmd.read_cap = 1'b1;
                    ov_next      = 1'b1;
                end
            ST_CLEAR:
            begin
                cmd.clr_step  = 1'b1;
                cmd.clr_color = clr_c_reg;
                cmd.clr_depth = clr_z_reg;
            end
            ST_DONE:
                if (out_free)
                begin
                    cmd.set_result = 1'b1;
                    ov_next        = 1'b1;
                end
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_c_reg     <= 1'b0;
            clr_z_reg     <= 1'b0;
            ov_reg        <= 1'b0;
            first_div_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_c_reg     <= clr_c_next;
            clr_z_reg     <= clr_z_next;
            ov_reg        <= ov_next;
            first_div_reg <= (state_reg == ST_MUL) && status.covered;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
endmodule

@@ tb/sv/raster_checker.sv @@
// Watches both channels of the triangle rasterizer, keeps its own copy of the
// color and depth stores, predicts each result beat and compares it.
// Depends on trd_pkg.
module raster_checker
    import trd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending,
    output int        draws_seen,
    output int        reads_seen,
    output int        clears_seen,
    output longint    pixels_total
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [23:0] depth_mem [PixCount];
    logic [23:0] color_mem [PixCount];
    out_item_t   expected_results [$];

    function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function automatic int draw_triangle(in_item_t it);
        longint vx [3];
        longint vy [3];
        longint vz [3];
        longint minx, maxx, miny, maxy, w0, w1, w2, num, den, z;
        int count;
        int idx;
        vx[0] = it.vert0_x; vy[0] = it.vert0_y; vz[0] = it.vert0_z;
        vx[1] = it.vert1_x; vy[1] = it.vert1_y; vz[1] = it.vert1_z;
        vx[2] = it.vert2_x; vy[2] = it.vert2_y; vz[2] = it.vert2_z;
        count = 0;
        minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx[i] < minx) minx = vx[i];
            if (vx[i] > maxx) maxx = vx[i];
            if (vy[i] < miny) miny = vy[i];
            if (vy[i] > maxy) maxy = vy[i];
        end
        for (longint x = minx / 16; x * 16 < maxx; x++)
        begin
            for (longint y = miny / 16; y * 16 < maxy; y++)
            begin
                w0 = edge_val(vx[1], vy[1], vx[2], vy[2], x * 16, y * 16);
                w1 = edge_val(vx[2], vy[2], vx[0], vy[0], x * 16, y * 16);
                w2 = edge_val(vx[0], vy[0], vx[1], vy[1], x * 16, y * 16);
                if (!((w0 > 0 && w1 > 0 && w2 > 0) || (w0 < 0 && w1 < 0 && w2 < 0)))
                    continue;
                if (x >= ScreenWidth || y >= ScreenHeight)
                    continue;
                if (w0 < 0)
                begin
                    w0 = -w0; w1 = -w1; w2 = -w2;
                end
                num = w0 * vz[0] + w1 * vz[1] + w2 * vz[2];
                den = w0 + w1 + w2;
                z = (num + den / 2) / den;
                if (z > 64'hFFFFFF) z = 64'hFFFFFF;
                idx = (ScreenHeight - 1 - int'(y)) * ScreenWidth + int'(x);
                if (z > depth_mem[idx])
                    continue;
                depth_mem[idx] = z[23:0];
                color_mem[idx] = it.fill_color;
                count++;
            end
        end
        return count;
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.kind)
            KIND_DRAW:
            begin
                r.pixels_written = 17'(draw_triangle(it));
                draws_seen++;
                pixels_total += r.pixels_written;
            end
            KIND_READ:
            begin
                reads_seen++;
                if (int'(it.pixel_addr) < PixCount)
                begin
                    r.read_color = color_mem[it.pixel_addr];
                    r.read_depth = depth_mem[it.pixel_addr];
                end
            end
            KIND_CLR_C:
            begin
                clears_seen++;
                foreach (color_mem[i]) color_mem[i] = '0;
            end
            KIND_CLR_Z:
            begin
                clears_seen++;
                foreach (depth_mem[i]) depth_mem[i] = '1;
            end
            KIND_CLR_B:
            begin
                clears_seen++;
                foreach (color_mem[i]) color_mem[i] = '0;
                foreach (depth_mem[i]) depth_mem[i] = '1;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        draws_seen = 0;
        reads_seen = 0;
        clears_seen = 0;
        pixels_total = 0;
        foreach (color_mem[i]) color_mem[i] = '0;
        foreach (depth_mem[i]) depth_mem[i] = '1;
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_result(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_data.pixels_written !== exp_r.pixels_written)
                    begin
                        $error("pixels_written expected %0d actual %0d",
                               exp_r.pixels_written, out_data.pixels_written);
                        fail_count++;
                    end
                    if (out_data.read_color !== exp_r.read_color)
                    begin
                        $error("read_color expected %06h actual %06h",
                               exp_r.read_color, out_data.read_color);
                        fail_count++;
                    end
                    if (out_data.read_depth !== exp_r.read_depth)
                    begin
                        $error("read_depth expected %06h actual %06h",
                               exp_r.read_depth, out_data.read_depth);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end
endmodule

@@ tb/sv/triangle_raster_depth_test_tb.sv @@
// Top of the rasterizer testbench: clock, reset, draw/read/clear stimulus
// and the verdict. Depends on trd_pkg, trd_if, the block and raster_checker.
module triangle_raster_depth_test_tb;
    import trd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KindSpareFirst = 3'd5;
    localparam logic [2:0] KindSpareLast  = 3'd7;
    localparam logic [23:0] ZFar = 24'hFFFFFE;
    localparam longint CycleLimit = 30_000_000;
    localparam int RandomItems = 1080;

    logic   clk;
    logic   rst_n;
    longint cycles;
    int     fail_count, pending, draws_seen, reads_seen, clears_seen;
    longint pixels_total;
    int     sender_idle_pct, receiver_stall_pct;
    int     win_x, win_y;

    trd_if #(.payload_t(in_item_t))  in_ch (clk);
    trd_if #(.payload_t(out_item_t)) out_ch (clk);

    triangle_raster_depth_test DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    raster_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_data     (in_ch.data),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_data    (out_ch.data),
        .fail_count  (fail_count),
        .pending     (pending),
        .draws_seen  (draws_seen),
        .reads_seen  (reads_seen),
        .clears_seen (clears_seen),
        .pixels_total(pixels_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("status: fail");
                $finish;
            end
        end
    end

    // The result side stalls at random in the phases that ask for it.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic in_item_t make_draw(int x0, int y0, int z0, int x1, int y1, int z1,
                                           int x2, int y2, int z2, int col);
        in_item_t it;
        it = '0;
        it.kind = KIND_DRAW;
        it.vert0_x = 12'(x0); it.vert0_y = 12'(y0); it.vert0_z = 24'(z0);
        it.vert1_x = 12'(x1); it.vert1_y = 12'(y1); it.vert1_z = 24'(z1);
        it.vert2_x = 12'(x2); it.vert2_y = 12'(y2); it.vert2_z = 24'(z2);
        it.fill_color = 24'(col);
        it.pixel_addr = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_other(logic [2:0] k, int addr);
        in_item_t it;
        it = make_draw($urandom, $urandom, $urandom_range(ZFar), $urandom, $urandom,
                       $urandom_range(ZFar), $urandom, $urandom, $urandom_range(ZFar), $urandom);
        it.kind = k;
        it.pixel_addr = 16'(addr);
        return it;
    endfunction

    function automatic int pixel_addr_of(int x, int y);
        return (ScreenHeight - 1 - y) * ScreenWidth + x;
    endfunction

    function automatic int near_coord(int base, int span);
        int v;
        v = base + $urandom_range(span);
        return (v > 4095) ? 4095 : v;
    endfunction

    function automatic int rand_depth();
        case ($urandom_range(9))
            0: return 0;
            1: return int'(ZFar);
            default: return $urandom_range(ZFar);
        endcase
    endfunction

    // Most triangles land in a small window so that they overlap and the
    // depth test decides; the rest go anywhere on the 8.4 grid.
    function automatic in_item_t random_draw();
        int bx, by, span;
        int xs [3];
        int ys [3];
        if ($urandom_range(9) < 7)
        begin
            bx = win_x * 16 + $urandom_range(96);
            by = win_y * 16 + $urandom_range(96);
        end
        else
        begin
            bx = $urandom_range(4095);
            by = $urandom_range(4095);
        end
        span = ($urandom_range(9) == 0) ? 96 : 48;
        for (int i = 0; i < 3; i++)
        begin
            xs[i] = near_coord(bx, span);
            ys[i] = near_coord(by, span);
        end
        if ($urandom_range(19) == 0)
        begin
            xs[2] = xs[1];
            ys[2] = ys[1];
        end
        return make_draw(xs[0], ys[0], rand_depth(), xs[1], ys[1], rand_depth(),
                         xs[2], ys[2], rand_depth(), $urandom);
    endfunction

    function automatic in_item_t random_item();
        int r;
        r = $urandom_range(999);
        if (r < 3)
            return make_other(3'($urandom_range(KIND_CLR_B, KIND_CLR_C)), $urandom);
        if (r < 10)
            return make_other(3'($urandom_range(KindSpareLast, KindSpareFirst)), $urandom);
        if (r < 500)
        begin
            if ($urandom_range(9) < 8)
                return make_other(KIND_READ, pixel_addr_of(win_x + $urandom_range(7),
                                                           win_y + $urandom_range(7)));
            return make_other(KIND_READ, $urandom);
        end
        return random_draw();
    endfunction

    // Drives one beat; returns after its accepting edge and any random idle
    // cycles with valid low. Input changes only at rising edges, so ready
    // seen at the falling edge decides acceptance at the next rising edge.
    task automatic send_beat(in_item_t it);
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (in_ch.ready)
            begin
                @(posedge clk);
                break;
            end
        end
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        win_x = 0;
        win_y = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: fresh stores, corners, both windings, degenerate
        // triangles, every clear and the unused kinds.
        send_beat(make_other(KIND_READ, 0));
        send_beat(make_other(KIND_READ, PixCount - 1));
        send_beat(make_draw(0, 0, 0, 64, 0, 0, 0, 64, 0, 24'hFFFFFF));
        send_beat(make_draw(0, 0, ZFar, 0, 64, ZFar, 64, 0, ZFar, 24'h123456));
        send_beat(make_other(KIND_READ, pixel_addr_of(1, 1)));
        send_beat(make_draw(8, 8, ZFar, 72, 20, 0, 30, 70, 100, 24'h00FF00));
        send_beat(make_other(KIND_READ, pixel_addr_of(2, 2)));
        send_beat(make_draw(4095, 4095, 7, 4000, 4095, 9, 4095, 4000, 3, 24'hABCDEF));
        send_beat(make_other(KIND_READ, pixel_addr_of(255, 255)));
        send_beat(make_draw(4000, 4000, 5, 4000, 4000, 5, 4000, 4000, 5, 24'h111111));
        send_beat(make_draw(10, 10, 5, 40, 40, 5, 70, 70, 5, 24'h222222));
        send_beat(make_draw(0, 4095, 1, 60, 4095, 2, 0, 4020, 3, 24'h0000FF));
        send_beat(make_other(KIND_READ, pixel_addr_of(1, 254)));
        send_beat(make_other(KIND_CLR_C, 0));
        send_beat(make_other(KIND_READ, pixel_addr_of(1, 1)));
        send_beat(make_other(KIND_CLR_Z, 0));
        send_beat(make_other(KIND_READ, pixel_addr_of(1, 1)));
        send_beat(make_draw(0, 0, 0, 64, 0, 0, 0, 64, 0, 24'hFFFFFF));
        send_beat(make_other(KIND_CLR_B, 0));
        send_beat(make_other(KIND_READ, pixel_addr_of(1, 1)));
        for (int k = int'(KindSpareFirst); k <= int'(KindSpareLast); k++)
            send_beat(make_other(3'(k), 16'hFFFF));

        // Random part in four phases of flow control.
        for (phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = (phase == 1) ? 83 : ((phase == 3) ? 6 : 0);
            receiver_stall_pct = (phase == 2) ? 83 : ((phase == 3) ? 6 : 0);
            win_x = $urandom_range(248);
            win_y = $urandom_range(248);
            for (int n = 0; n < RandomItems / 4; n++)
                send_beat(random_item());
        end
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d draws (%0d pixels written), %0d reads, %0d clears in %0d cycles",
                 draws_seen, pixels_total, reads_seen, clears_seen, cycles);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

@@ triangle_raster_depth_test.f @@
+incdir+design
design/trd_pkg.sv
design/trd_if.sv
design/trd_div.sv
design/trd_datapath.sv
design/trd_ctrl.sv
design/triangle_raster_depth_test.sv
tb/sv/raster_checker.sv
tb/sv/triangle_raster_depth_test_tb.sv
